>>> rtl/core/hbm_pkg.sv
// ----------------------------------------------------------------------------
// hbm_pkg
// Shared types and mixing constants for the byte hash word mixer.
// ----------------------------------------------------------------------------
package hbm_pkg;

   localparam logic [31:0] MIX_ADD_A  = 32'd14921776;
   localparam logic [31:0] MIX_MUL_A  = 32'd17761492;
   localparam logic [31:0] MIX_XOR_A  = 32'h0582_7066;
   localparam logic [31:0] MIX_ADD_B  = 32'h0002_c357;
   localparam logic [31:0] MIX_MUL_B  = 32'd10661688;

   // another round runs while bit 31 is clear and bit 1 is set
   localparam logic [31:0] MIX_LOOP_MASK  = 32'h8000_0002;
   localparam logic [31:0] MIX_LOOP_MATCH = 32'h0000_0002;

   localparam int          MIX_ROUND_CAP = 256;
   localparam int          MIX_ROUND_W   = 8;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_XOR,
      ALU_MUL_A,
      ALU_ADD_A,
      ALU_MUL_B,
      ALU_ADD_B
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_CUR,
      ST_MUL_A,
      ST_ADD_A,
      ST_MUL_B,
      ST_ADD_B,
      ST_WRITE,
      ST_DIGEST
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } ram_ctl_type;

endpackage

>>> rtl/core/byte_hash_five_word_mixer.sv
// ----------------------------------------------------------------------------
// byte_hash_five_word_mixer
// Byte hash over a ring of mixed 32-bit words with an iterated mixing function.
// ----------------------------------------------------------------------------
// Each request absorbs one byte and returns one digest. A request runs a
// load step, R mixing rounds, a write step and a digest step before the next
// request can be taken, where R is the number of mixing rounds the byte needs
// (1 to 256, data dependent, almost always small). Each round uses the single
// shared multiplier unit for two multiplies, each followed by its add step.
// The word ring sits in a one-port-read memory with registered reads.
// A new request is taken while the previous digest still waits on rsp_stall.
// ----------------------------------------------------------------------------
module byte_hash_five_word_mixer #(
   parameter int WORD_COUNT = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest
);
   import hbm_pkg::*;

   localparam int                     PosW      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam logic [PosW-1:0]        PosLast   = PosW'(WORD_COUNT - 1);
   localparam logic [MIX_ROUND_W-1:0] RoundLast = MIX_ROUND_W'(MIX_ROUND_CAP - 1);

   state_type               state_ff, state_in;
   logic [PosW-1:0]         pos_ff, pos_in;
   logic [7:0]              byte_ff, byte_in;
   logic [31:0]             acc_ff, acc_in;
   logic [31:0]             prod_ff, prod_in;
   logic [MIX_ROUND_W-1:0]  round_ff, round_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_digest_ff, rsp_digest_in;

   logic                    req_fire;
   logic                    rsp_free;
   logic [PosW-1:0]         pos_nxt;
   logic [PosW-1:0]         pos_nxt2;
   alu_op_type              alu_op;
   logic [31:0]             alu_a;
   logic [31:0]             alu_b;
   logic [31:0]             alu_y;
   ram_ctl_type             ram_ctl;
   logic [PosW-1:0]         rd_addr;
   logic [PosW-1:0]         wr_addr;
   logic [31:0]             rd_data;
   logic                    mix_again;

   assign req_fire = req_valid & ~req_stall;
   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;
   assign pos_nxt  = (pos_ff == PosLast)  ? '0 : pos_ff + PosW'(1);
   assign pos_nxt2 = (pos_nxt == PosLast) ? '0 : pos_nxt + PosW'(1);
   assign mix_again = ((alu_y & MIX_LOOP_MASK) == MIX_LOOP_MATCH) && (round_ff != RoundLast);

   hbm_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   hbm_word_ram #(
      .WORD_COUNT (WORD_COUNT),
      .ADDR_W     (PosW)
   ) u_word_ram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ram_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (alu_y),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_fire) state_in = ST_LOAD_CUR;
         ST_LOAD_CUR: state_in = ST_MUL_A;
         ST_MUL_A:    state_in = ST_ADD_A;
         ST_ADD_A:    state_in = ST_MUL_B;
         ST_MUL_B:    state_in = ST_ADD_B;
         ST_ADD_B:    state_in = mix_again ? ST_MUL_A : ST_WRITE;
         ST_WRITE:    state_in = ST_DIGEST;
         ST_DIGEST:   if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      alu_op    = ALU_ADD;
      alu_a     = acc_ff;
      alu_b     = rd_data;
      ram_ctl   = '0;
      rd_addr   = pos_ff;
      wr_addr   = pos_nxt;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            ram_ctl.rd_en = req_fire;
            ram_ctl.clear = req_fire & req_restart;
            rd_addr       = req_restart ? '0 : pos_ff;
         end
         ST_LOAD_CUR: begin
            alu_op        = ALU_ADD;
            alu_a         = rd_data;
            alu_b         = {24'd0, byte_ff};
            ram_ctl.rd_en = 1'b1;
            rd_addr       = pos_nxt;
         end
         ST_MUL_A: alu_op = ALU_MUL_A;
         ST_ADD_A: begin
            alu_op = ALU_ADD_A;
            alu_b  = prod_ff;
         end
         ST_MUL_B: alu_op = ALU_MUL_B;
         ST_ADD_B: begin
            alu_op = ALU_ADD_B;
            alu_b  = prod_ff;
         end
         ST_WRITE: begin
            alu_op        = ALU_ADD;
            ram_ctl.wr_en = 1'b1;
            wr_addr       = pos_nxt;
            ram_ctl.rd_en = 1'b1;
            rd_addr       = pos_nxt2;
         end
         ST_DIGEST: alu_op = ALU_XOR;
         default:   req_stall = 1'b1;
      endcase
   end

   // datapath next values
   always_comb begin
      pos_in        = pos_ff;
      byte_in       = byte_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      round_in      = round_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_digest_in = rsp_digest_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               byte_in  = req_data_byte;
               pos_in   = req_restart ? '0 : pos_ff;
               round_in = '0;
            end
         end
         ST_LOAD_CUR: acc_in  = alu_y;
         ST_MUL_A:    prod_in = alu_y;
         ST_ADD_A:    acc_in  = alu_y;
         ST_MUL_B:    prod_in = alu_y;
         ST_ADD_B: begin
            acc_in   = alu_y;
            round_in = round_ff + MIX_ROUND_W'(1);
         end
         ST_WRITE: begin
            acc_in = alu_y;
            pos_in = pos_nxt;
         end
         ST_DIGEST: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_digest_in = alu_y;
            end
         end
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_digest_ff <= rsp_digest_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_digest = rsp_digest_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosLast)
      else $error("position out of range");

   a_rd_wr_apart: assert property (@(posedge clock) disable iff (reset)
      ram_ctl.wr_en |-> (ram_ctl.rd_en && (rd_addr != wr_addr)))
      else $error("word read and write collide");

   a_rsp_from_digest: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DIGEST))
      else $error("response raised outside digest state");

   a_round_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD_B && round_ff == RoundLast) |=> state_ff == ST_WRITE)
      else $error("mixing ran past round cap");

endmodule

>>> rtl/core/hbm_alu.sv
// ----------------------------------------------------------------------------
// hbm_alu
// Shared 32-bit arithmetic unit: one multiplier plus add, xor and fold logic.
// ----------------------------------------------------------------------------
module hbm_alu (
   input  hbm_pkg::alu_op_type op,
   input  logic [31:0]         a,
   input  logic [31:0]         b,
   output logic [31:0]         y
);
   import hbm_pkg::*;

   logic [31:0] mul_opnd;
   logic [31:0] mul_y;
   logic [31:0] sum_a;
   logic [31:0] sum_b;

   assign mul_opnd = (op == ALU_MUL_A) ? (MIX_MUL_A + a) : (MIX_MUL_B ^ a);
   assign mul_y    = 32'(a * mul_opnd);
   assign sum_a    = a + MIX_ADD_A + b;
   assign sum_b    = a + MIX_ADD_B + b;

   always_comb begin
      case (op)
         ALU_ADD:   y = a + b;
         ALU_XOR:   y = a ^ b;
         ALU_MUL_A: y = mul_y;
         ALU_ADD_A: y = sum_a ^ MIX_XOR_A;
         ALU_MUL_B: y = mul_y;
         ALU_ADD_B: y = sum_b ^ {16'd0, sum_b[31:16]};
         default:   y = a;
      endcase
   end

endmodule

>>> rtl/core/hbm_word_ram.sv
// ----------------------------------------------------------------------------
// hbm_word_ram
// Word ring storage with registered read and per-word valid bits.
// ----------------------------------------------------------------------------
module hbm_word_ram #(
   parameter int WORD_COUNT = 5,
   parameter int ADDR_W     = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hbm_pkg::ram_ctl_type ctl,
   input  logic [ADDR_W-1:0]    rd_addr,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [31:0]          wr_data,
   output logic [31:0]          rd_data
);
   import hbm_pkg::*;

   logic [31:0]           mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] vld_ff;
   logic [31:0]           rd_data_ff;
   logic                  rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.clear) begin
            vld_ff <= '0;
         end else if (ctl.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr] & ~ctl.clear;
         end
      end
   end

   // an unwritten word reads as zero
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule
